// ===== src/hill_cipher_block_mod256_unit_macros.svh =====
// Assertion shorthands for the Hill cipher block checkers.
// All of them sample on i_clk; the first two are muted while i_rst_n is low.
`ifndef HILL_CIPHER_BLOCK_MOD256_UNIT_MACROS_SVH
`define HILL_CIPHER_BLOCK_MOD256_UNIT_MACROS_SVH

// Same-cycle implication, ignored during reset.
`define HCB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcb check failed");

// Next-cycle implication, ignored during reset.
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcb check failed");

// Next-cycle implication that also holds through reset.
`define HCB_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hcb reset check failed");

`endif

// ===== src/hcb_pkg.sv =====
package hcb_pkg;

    // Sizes fixed by the word formats
    localparam int DEF_MAX_DIMENSION = 4;
    localparam int DATA_W            = 8;
    localparam int DIM_W             = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_ADDR_W        = 6;
    localparam int MAT_BYTES         = 16;
    localparam int MAT_IDX_W         = 4;

    // Register indexes (paddr[5:3])
    localparam logic [2:0] REG_DIMENSION  = 3'd0;
    localparam logic [2:0] REG_DECRYPT    = 3'd1;
    localparam logic [2:0] REG_KEY_LOW    = 3'd2;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd3;
    localparam logic [2:0] REG_INV_LOW    = 3'd4;
    localparam logic [2:0] REG_INV_HIGH   = 3'd5;

    typedef struct packed {
        logic [DIM_W-1:0]      dimension;
        logic                  decrypt_mode;
        logic [CFG_DATA_W-1:0] key_low;
        logic [CFG_DATA_W-1:0] key_high;
        logic [CFG_DATA_W-1:0] inv_low;
        logic [CFG_DATA_W-1:0] inv_high;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic take;      // input word accepted this cycle
        logic row_clr;   // restart the row counter
        logic row_step;  // compute current row into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic complete;  // the offered word closes the vector
        logic last_row;  // current row is the last one
        logic out_free;  // output register can take a word
    } t_stat;

endpackage

// ===== src/hcb_if.sv =====
// Input channel: one byte of the message per word
interface hcb_in_if;
    logic                      valid;
    logic                      ready;
    logic [hcb_pkg::DATA_W-1:0] data_byte;
    logic                      final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Output channel: one row result per word
interface hcb_out_if;
    logic                      valid;
    logic                      ready;
    logic [hcb_pkg::DATA_W-1:0] result_byte;
    logic                      block_end;

    modport source (output valid, output result_byte, output block_end, input ready);
    modport sink   (input valid, input result_byte, input block_end, output ready);
endinterface

// ===== src/hcb_regs.sv =====
module hcb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hcb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hcb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output hcb_pkg::t_cfg                  o_cfg
);
    import hcb_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[CFG_ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dimension    <= DIM_W'(1);
            r_cfg.decrypt_mode <= 1'b0;
            r_cfg.key_low      <= '0;
            r_cfg.key_high     <= '0;
            r_cfg.inv_low      <= '0;
            r_cfg.inv_high     <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DIMENSION: r_cfg.dimension    <= pwdata[DIM_W-1:0];
                REG_DECRYPT:   r_cfg.decrypt_mode <= pwdata[0];
                REG_KEY_LOW:   r_cfg.key_low      <= pwdata;
                REG_KEY_HIGH:  r_cfg.key_high     <= pwdata;
                REG_INV_LOW:   r_cfg.inv_low      <= pwdata;
                REG_INV_HIGH:  r_cfg.inv_high     <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_DIMENSION: prdata = CFG_DATA_W'(r_cfg.dimension);
            REG_DECRYPT:   prdata = CFG_DATA_W'(r_cfg.decrypt_mode);
            REG_KEY_LOW:   prdata = r_cfg.key_low;
            REG_KEY_HIGH:  prdata = r_cfg.key_high;
            REG_INV_LOW:   prdata = r_cfg.inv_low;
            REG_INV_HIGH:  prdata = r_cfg.inv_high;
            default:       prdata = '0;
        endcase
    end
endmodule

// ===== src/hcb_ctrl.sv =====
module hcb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hcb_pkg::t_stat i_stat,
    output hcb_pkg::t_cmd  o_cmd
);
    import hcb_pkg::*;

    localparam logic ST_GATHER = 1'b0;  // taking bytes into the vector
    localparam logic ST_EMIT   = 1'b1;  // sending one row per free output slot

    logic r_state;
    logic n_state;

    assign o_in_ready = (r_state == ST_GATHER);

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.take     = 1'b0;
        o_cmd.row_clr  = 1'b0;
        o_cmd.row_step = 1'b0;
        unique case (r_state)
            ST_GATHER: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.complete) begin
                        o_cmd.row_clr = 1'b1;
                        n_state       = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.row_step = 1'b1;
                    if (i_stat.last_row) begin
                        n_state = ST_GATHER;
                    end
                end
            end
            default: n_state = ST_GATHER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_GATHER;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== src/hcb_dp.sv =====
module hcb_dp #(
    parameter int MAX_DIMENSION = hcb_pkg::DEF_MAX_DIMENSION
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hcb_pkg::t_cfg              i_cfg,
    input  hcb_pkg::t_cmd              i_cmd,
    output hcb_pkg::t_stat             o_stat,
    input  logic [hcb_pkg::DATA_W-1:0] i_data_byte,
    input  logic                       i_final_byte,
    output logic [hcb_pkg::DATA_W-1:0] o_result_byte,
    output logic                       o_block_end,
    output logic                       o_valid,
    input  logic                       i_ready
);
    import hcb_pkg::*;

    localparam int CW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      r_row;
    logic [DATA_W-1:0]  r_buf [MAX_DIMENSION];
    logic [DATA_W-1:0]  r_vec [MAX_DIMENSION];
    logic [DATA_W-1:0]  r_out_byte;
    logic               r_out_end;
    logic               r_out_valid;

    logic [DIM_W-1:0]           w_dim;
    logic [DIM_W-1:0]           w_pos;
    logic [DIM_W-1:0]           w_pos_inc;
    logic [DIM_W-1:0]           w_cnt;
    logic                       w_complete;
    logic                       w_last_row;
    logic [MAT_BYTES*DATA_W-1:0] w_mat;
    logic [MAT_IDX_W-1:0]       w_base;
    logic [DATA_W-1:0]          w_sum;
    logic [2*DATA_W-1:0]        w_prod [MAX_DIMENSION];

    // Active dimension: zero acts as one, clamp to the lane count
    always_comb begin
        w_dim = i_cfg.dimension;
        if (w_dim == '0) begin
            w_dim = DIM_W'(1);
        end
        if (w_dim > DIM_W'(MAX_DIMENSION)) begin
            w_dim = DIM_W'(MAX_DIMENSION);
        end
    end

    // Gather position and completion
    assign w_pos      = DIM_W'(r_fill);
    assign w_pos_inc  = w_pos + DIM_W'(1);
    assign w_cnt      = (w_pos_inc > w_dim) ? w_dim : w_pos_inc;
    assign w_complete = (w_cnt == w_dim) || i_final_byte;
    assign w_last_row = ((DIM_W'(r_row) + DIM_W'(1)) == w_dim);

    assign o_stat.complete = w_complete;
    assign o_stat.last_row = w_last_row;
    assign o_stat.out_free = !r_out_valid || i_ready;

    // Vector buffer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.take) begin
            r_fill <= w_complete ? '0 : CW'(w_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (w_pos < w_dim)) begin
            r_buf[r_fill] <= i_data_byte;
        end
    end

    // Snapshot of the finished vector; unfilled places read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && w_complete) begin
            for (int j = 0; j < MAX_DIMENSION; j++) begin
                if (DIM_W'(j) >= w_cnt) begin
                    r_vec[j] <= '0;
                end else if (DIM_W'(j) == w_pos) begin
                    r_vec[j] <= i_data_byte;
                end else begin
                    r_vec[j] <= r_buf[j];
                end
            end
        end
    end

    // Row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_cmd.row_clr) begin
            r_row <= '0;
        end else if (i_cmd.row_step) begin
            r_row <= r_row + CW'(1);
        end
    end

    // One row: a byte multiplier per lane, summed modulo 256
    assign w_mat  = i_cfg.decrypt_mode ? {i_cfg.inv_high, i_cfg.inv_low}
                                       : {i_cfg.key_high, i_cfg.key_low};
    assign w_base = MAT_IDX_W'(MAT_IDX_W'(r_row) * MAT_IDX_W'(w_dim));

    always_comb begin
        logic [MAT_IDX_W-1:0] k;
        w_sum = '0;
        for (int j = 0; j < MAX_DIMENSION; j++) begin
            k         = w_base + MAT_IDX_W'(j);
            w_prod[j] = w_mat[k*DATA_W +: DATA_W] * r_vec[j];
            w_sum     = w_sum + w_prod[j][DATA_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.row_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_step) begin
            r_out_byte <= w_sum;
            r_out_end  <= w_last_row;
        end
    end

    assign o_result_byte = r_out_byte;
    assign o_block_end   = r_out_end;
    assign o_valid       = r_out_valid;
endmodule

// ===== src/hill_cipher_block_mod256_unit.sv =====
// The word that closes a vector is copied into the vector register as the sequencer
//   enters row output; rows then leave through the output register, one row per
//   cycle while the sink keeps up, from one shared MAX_DIMENSION-lane multiply-add.
//   Bytes are taken one per cycle while gathering, and none while rows are pending.
// Reset (i_rst_n low, synchronous): fill count, row counter and output valid clear;
//   dimension returns to 1, mode to encrypt, both matrices to zero.
module hill_cipher_block_mod256_unit #(
    parameter int MAX_DIMENSION = hcb_pkg::DEF_MAX_DIMENSION
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hcb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hcb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    hcb_in_if.sink                         i_in,
    hcb_out_if.source                      o_out
);
    import hcb_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // Configuration registers
    hcb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // Vector gather, row multiply-add, output register
    hcb_dp #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_data_byte   (i_in.data_byte),
        .i_final_byte  (i_in.final_byte),
        .o_result_byte (o_out.result_byte),
        .o_block_end   (o_out.block_end),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready)
    );
endmodule

// ===== src/hcb_checker.sv =====
`include "hill_cipher_block_mod256_unit_macros.svh"

module hcb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic                       i_final_byte,
    input logic                       o_valid,
    input logic                       o_ready,
    input logic [hcb_pkg::DATA_W-1:0] o_result_byte,
    input logic                       o_block_end
);
    // A stalled result word holds
    `HCB_ASSERT_NEXT(a_out_hold, o_valid && !o_ready, o_valid && $stable({o_result_byte, o_block_end}))
    // No byte is taken while rows of a block are still pending
    `HCB_ASSERT_SAME(a_no_take_mid_block, o_valid && !o_block_end, !i_ready)
    // A final byte always closes the vector and starts row output
    `HCB_ASSERT_NEXT(a_final_closes, i_valid && i_ready && i_final_byte, !i_ready)
    // Reset empties the output register
    `HCB_ASSERT_RESET(a_reset_empty, !i_rst_n, !o_valid)
endmodule

bind hill_cipher_block_mod256_unit hcb_checker u_hcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_in.valid),
    .i_ready       (i_in.ready),
    .i_final_byte  (i_in.final_byte),
    .o_valid       (o_out.valid),
    .o_ready       (o_out.ready),
    .o_result_byte (o_out.result_byte),
    .o_block_end   (o_out.block_end)
);

// ===== bench/hill_cipher_block_mod256_unit_tb.sv =====
module hill_cipher_block_mod256_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcb_pkg::*;

    localparam int RANDOM_ITEMS  = 305;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;

    // One message byte on its way into the block
    typedef struct {
        logic [DATA_W-1:0] value;
        logic              is_last;
    } t_msg_word;

    // One row result the block owes us
    typedef struct {
        logic [DATA_W-1:0] value;
        logic              closes_block;
    } t_row_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    hcb_in_if  in_if ();
    hcb_out_if out_if ();

    hill_cipher_block_mod256_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the block: register file, gathered vector and fill count
    t_cfg              cipher_cfg;
    logic [DATA_W-1:0] gathered [DEF_MAX_DIMENSION];
    int unsigned       gather_count;

    t_msg_word msg_words [$];
    t_row_word rows_owed [$];
    t_msg_word next_word;

    int  words_queued;
    int  words_taken;
    int  rows_checked;
    int  blocks_checked;
    int  settings_run;
    int  fail_count;
    int  gap_left;
    int  stall_left;
    logic in_took;
    logic steady;

    // Gather one byte; when the vector closes, queue the matrix-vector rows mod 256
    function automatic void absorb_byte(logic [DATA_W-1:0] value, logic is_last);
        int unsigned       dim;
        int unsigned       pos;
        int unsigned       filled;
        int unsigned       k;
        logic [63:0]       mat_low;
        logic [63:0]       mat_high;
        logic [DATA_W-1:0] coef;
        logic [DATA_W-1:0] acc;
        t_row_word         row;

        dim = cipher_cfg.dimension;
        if (dim < 1) dim = 1;
        if (dim > DEF_MAX_DIMENSION) dim = DEF_MAX_DIMENSION;

        // bytes past the current dimension are dropped
        pos = gather_count;
        if (pos < dim) gathered[pos] = value;
        filled = pos + 1;
        if (filled > dim) filled = dim;

        if (filled < dim && !is_last) begin
            gather_count = filled;
            return;
        end

        mat_low  = cipher_cfg.decrypt_mode ? cipher_cfg.inv_low  : cipher_cfg.key_low;
        mat_high = cipher_cfg.decrypt_mode ? cipher_cfg.inv_high : cipher_cfg.key_high;
        for (int i = 0; i < dim; i++) begin
            acc = '0;
            // unfilled positions of a short vector count as zero
            for (int j = 0; j < filled; j++) begin
                k = i * dim + j;
                coef = (k < 8) ? mat_low[8*(k%8) +: 8] : mat_high[8*(k%8) +: 8];
                acc += coef * gathered[j];
            end
            row.value        = acc;
            row.closes_block = (i == dim - 1);
            rows_owed.push_back(row);
        end
        gather_count = 0;
    endfunction

    // Input driver: one word per handshake, random gap bursts between words
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (msg_words.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 14) - 1;
                in_if.valid <= 1'b0;
            end else begin
                next_word = msg_words.pop_front();
                in_if.valid      <= 1'b1;
                in_if.data_byte  <= next_word.value;
                in_if.final_byte <= next_word.is_last;
            end
        end
    end

    // Output back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted byte, check each accepted result
    always @(posedge i_clk) begin
        t_row_word owed;
        in_took <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            absorb_byte(in_if.data_byte, in_if.final_byte);
            words_taken++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (rows_owed.size() == 0) begin
                $error("unexpected result word: result_byte %0h block_end %0b",
                       out_if.result_byte, out_if.block_end);
                fail_count++;
            end else begin
                owed = rows_owed.pop_front();
                if (out_if.result_byte !== owed.value) begin
                    $error("result_byte: expected %0h, got %0h",
                           owed.value, out_if.result_byte);
                    fail_count++;
                end
                if (out_if.block_end !== owed.closes_block) begin
                    $error("block_end: expected %0b, got %0b",
                           owed.closes_block, out_if.block_end);
                    fail_count++;
                end
                rows_checked++;
                if (owed.closes_block) blocks_checked++;
            end
        end
    end

    task automatic queue_word(logic [DATA_W-1:0] value, logic is_last);
        t_msg_word w;
        w.value   = value;
        w.is_last = is_last;
        msg_words.push_back(w);
        words_queued++;
    endtask

    // Wait until every byte is in and every row is out, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        while (words_taken != words_queued || rows_owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup then access, register lands on the access edge
    task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DIMENSION: cipher_cfg.dimension    = value[DIM_W-1:0];
            REG_DECRYPT:   cipher_cfg.decrypt_mode = value[0];
            REG_KEY_LOW:   cipher_cfg.key_low      = value;
            REG_KEY_HIGH:  cipher_cfg.key_high     = value;
            REG_INV_LOW:   cipher_cfg.inv_low      = value;
            REG_INV_HIGH:  cipher_cfg.inv_high     = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [63:0] pick_matrix();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int random_sent;
        int phase_items;
        int len;
        int dim_pick;
        logic ends;

        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.final_byte = 1'b0;
        out_if.ready     = 1'b0;
        in_took          = 1'b0;
        steady           = 1'b0;
        gap_left         = 0;
        stall_left       = 0;
        words_queued     = 0;
        words_taken      = 0;
        rows_checked     = 0;
        blocks_checked   = 0;
        settings_run     = 0;
        fail_count       = 0;
        random_sent      = 0;

        cipher_cfg           = '0;
        cipher_cfg.dimension = 3'd1;
        gather_count         = 0;
        foreach (gathered[i]) gathered[i] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: dimension 1, zero key, every byte is its own block
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b1);
        settle();

        // full 4-byte block, then a padded one-byte block
        write_reg(REG_DIMENSION, 64'd4);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        write_reg(REG_INV_LOW, {$urandom, $urandom});
        write_reg(REG_INV_HIGH, {$urandom, $urandom});
        write_reg(REG_DECRYPT, 64'd0);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_word(8'h01, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'hAA, 1'b1);
        settle();

        // decrypt with a short final vector
        write_reg(REG_DECRYPT, 64'd1);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word($urandom_range(0, 255), 1'b1);
        settle();

        // dimension shrinks under a part-filled vector
        queue_word($urandom_range(0, 255), 1'b0);
        queue_word($urandom_range(0, 255), 1'b0);
        queue_word($urandom_range(0, 255), 1'b0);
        settle();
        write_reg(REG_DIMENSION, 64'd2);
        queue_word(8'h55, 1'b0);
        settle();

        // mode flips under a part-filled vector
        write_reg(REG_DIMENSION, 64'd3);
        queue_word($urandom_range(0, 255), 1'b0);
        settle();
        write_reg(REG_DECRYPT, 64'd0);
        queue_word($urandom_range(0, 255), 1'b0);
        queue_word($urandom_range(0, 255), 1'b0);
        settle();

        // dimension zero acts as one
        write_reg(REG_DIMENSION, 64'd0);
        queue_word(8'h7F, 1'b0);
        queue_word(8'h01, 1'b1);
        settle();

        // dimension above four is clamped; full block that also carries final
        write_reg(REG_DIMENSION, 64'd7);
        queue_word($urandom_range(0, 255), 1'b0);
        queue_word($urandom_range(0, 255), 1'b0);
        queue_word($urandom_range(0, 255), 1'b0);
        queue_word($urandom_range(0, 255), 1'b1);
        settle();
        settings_run = 7;

        // random messages under random settings, no idling near the end
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS - 60) steady = 1'b1;
            settle();
            dim_pick = $urandom_range(0, 9);
            if (dim_pick < 8)
                write_reg(REG_DIMENSION, 64'(1 + dim_pick % 4));
            else if (dim_pick == 8)
                write_reg(REG_DIMENSION, 64'd0);
            else
                write_reg(REG_DIMENSION, 64'($urandom_range(5, 7)));
            write_reg(REG_DECRYPT, 64'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) write_reg(REG_KEY_LOW, pick_matrix());
            if ($urandom_range(0, 1)) write_reg(REG_KEY_HIGH, pick_matrix());
            if ($urandom_range(0, 1)) write_reg(REG_INV_LOW, pick_matrix());
            if ($urandom_range(0, 1)) write_reg(REG_INV_HIGH, pick_matrix());
            settings_run++;

            phase_items = 0;
            while (phase_items < 30 && random_sent < RANDOM_ITEMS) begin
                len  = $urandom_range(1, 9);
                // most messages end with a final byte, the rest run on
                ends = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < len; k++)
                    queue_word($urandom_range(0, 255), ends && (k == len - 1));
                phase_items += len;
                random_sent += len;
            end
        end
        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Drove %0d message bytes under %0d register settings.",
                 words_taken, settings_run);
        $display("Checked %0d result bytes in %0d blocks.", rows_checked, blocks_checked);
        if (fail_count == 0 && rows_owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (rows_owed.size() != 0)
                $error("%0d result words never arrived", rows_owed.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $error("timeout: %0d bytes taken of %0d, %0d results outstanding",
               words_taken, words_queued, rows_owed.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== hill_cipher_block_mod256_unit.f =====
+incdir+src
src/hcb_pkg.sv
src/hcb_if.sv
src/hcb_regs.sv
src/hcb_ctrl.sv
src/hcb_dp.sv
src/hill_cipher_block_mod256_unit.sv
src/hcb_checker.sv
bench/hill_cipher_block_mod256_unit_tb.sv
